FILE: sv/indexed_list_insert_remove_top_macros.svh
// ----------------------------------------------------------------------------
// indexed list assertion macros
// shared property forms for the indexed list block
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_TOP_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ILIR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ILIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// sizes, codes and state type of the indexed list block
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

    localparam int CAPACITY    = 64;
    localparam int WORD_BITS   = 32;
    localparam int KIND_BITS   = 3;
    localparam int POS_BITS    = 7;
    localparam int STATUS_BITS = 2;
    localparam int ADDR_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
    // common width for comparing positions against the count
    localparam int CMP_BITS    = (POS_BITS > COUNT_BITS) ? POS_BITS : COUNT_BITS;

    localparam logic [KIND_BITS-1:0] K_PUSH   = 3'd0;
    localparam logic [KIND_BITS-1:0] K_INSERT = 3'd1;
    localparam logic [KIND_BITS-1:0] K_SET    = 3'd2;
    localparam logic [KIND_BITS-1:0] K_POP    = 3'd3;
    localparam logic [KIND_BITS-1:0] K_REMOVE = 3'd4;
    localparam logic [KIND_BITS-1:0] K_GET    = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: sv/indexed_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top
// ordered word list in a ram with push, insert, set, pop, remove and get
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_kind, i_position, i_word_in
//  response  out        o_out_valid / i_out_stall o_word_out, o_status,
//                                                 o_entries_used
//
//  push, set, an insert at the end and every failed request go straight to
//  the done state; pop and get first pass through a ram read state
//  insert and remove shift one entry per cycle through the single ram
//  write port
//  a new request is taken once the previous one has reached the response
//  register, even while that response is stalled
//  synchronous active-low reset empties the list and stalls the request side;
//  the ram is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove_top
    import ilir_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [KIND_BITS-1:0]   i_kind,
    input  wire logic [POS_BITS-1:0]    i_position,
    input  wire logic [WORD_BITS-1:0]   i_word_in,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [WORD_BITS-1:0]        o_word_out,
    output logic [STATUS_BITS-1:0]      o_status,
    output logic [COUNT_BITS-1:0]       o_entries_used
);

    t_state                 r_state, n_state;
    logic [KIND_BITS-1:0]   r_kind;
    logic [POS_BITS-1:0]    r_pos;
    logic [WORD_BITS-1:0]   r_word;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [ADDR_BITS-1:0]   r_dst, n_dst;
    logic [WORD_BITS-1:0]   r_res_word, n_res_word;
    logic [STATUS_BITS-1:0] r_res_status, n_res_status;
    logic                   r_out_valid;
    logic [WORD_BITS-1:0]   r_out_word;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [COUNT_BITS-1:0]  r_out_count;

    logic                   in_acc;
    logic                   out_free;
    logic [STATUS_BITS-1:0] chk_status;
    logic [CMP_BITS-1:0]    in_pos_ext;
    logic [CMP_BITS-1:0]    cnt_ext;
    logic [CMP_BITS-1:0]    r_pos_ext;
    logic [CMP_BITS-1:0]    dst_ext;
    logic                   rm_first_more;
    logic                   rm_more;
    logic                   ins_more;

    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [WORD_BITS-1:0]   wr_data;
    logic                   rd_en;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [WORD_BITS-1:0]   rd_data;

    ilir_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign in_pos_ext = CMP_BITS'(i_position);
    assign cnt_ext    = CMP_BITS'(r_count);
    assign r_pos_ext  = CMP_BITS'(r_pos);
    assign dst_ext    = CMP_BITS'(r_dst);

    // remove: entries above the hole still to move down
    assign rm_first_more = (r_pos_ext + CMP_BITS'(1)) < cnt_ext;
    assign rm_more       = (dst_ext + CMP_BITS'(2)) < cnt_ext;
    // insert: entries above the gap still to move up
    assign ins_more      = dst_ext > (r_pos_ext + CMP_BITS'(1));

    always_comb begin
        chk_status = ST_OK;
        case (i_kind)
            K_PUSH: begin
                if (r_count == COUNT_BITS'(CAPACITY)) chk_status = ST_FULL;
            end
            K_INSERT: begin
                if (in_pos_ext > cnt_ext) chk_status = ST_RANGE;
                else if (r_count == COUNT_BITS'(CAPACITY)) chk_status = ST_FULL;
            end
            K_SET, K_GET: begin
                if (in_pos_ext >= cnt_ext) chk_status = ST_RANGE;
            end
            K_POP: begin
                if (r_count == '0) chk_status = ST_EMPTY;
            end
            K_REMOVE: begin
                if (r_count == '0) chk_status = ST_EMPTY;
                else if (in_pos_ext >= cnt_ext) chk_status = ST_RANGE;
            end
            default: chk_status = ST_OK;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (chk_status != ST_OK) begin
                        n_state = S_DONE;
                    end else begin
                        case (i_kind)
                            K_POP, K_GET, K_REMOVE: n_state = S_FIRST;
                            K_INSERT: n_state = (in_pos_ext == cnt_ext) ? S_DONE : S_SHIFT;
                            default: n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_FIRST: begin
                n_state = (r_kind == K_REMOVE && rm_first_more) ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                if (r_kind == K_INSERT) n_state = ins_more ? S_SHIFT : S_PLACE;
                else n_state = rm_more ? S_SHIFT : S_DONE;
            end
            S_PLACE: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ram accesses, count and result
    always_comb begin
        n_count      = r_count;
        n_dst        = r_dst;
        n_res_word   = r_res_word;
        n_res_status = r_res_status;
        wr_en        = 1'b0;
        wr_addr      = r_dst;
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = ADDR_BITS'(r_pos);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_status = chk_status;
                    n_res_word   = '0;
                    if (chk_status == ST_OK) begin
                        case (i_kind)
                            K_PUSH: begin
                                wr_en   = 1'b1;
                                wr_addr = ADDR_BITS'(r_count);
                                wr_data = i_word_in;
                                n_count = r_count + COUNT_BITS'(1);
                            end
                            K_SET: begin
                                wr_en   = 1'b1;
                                wr_addr = ADDR_BITS'(i_position);
                                wr_data = i_word_in;
                            end
                            K_GET, K_REMOVE: begin
                                rd_en   = 1'b1;
                                rd_addr = ADDR_BITS'(i_position);
                            end
                            K_POP: begin
                                rd_en   = 1'b1;
                                rd_addr = ADDR_BITS'(r_count - COUNT_BITS'(1));
                                n_count = r_count - COUNT_BITS'(1);
                            end
                            K_INSERT: begin
                                if (in_pos_ext == cnt_ext) begin
                                    wr_en   = 1'b1;
                                    wr_addr = ADDR_BITS'(r_count);
                                    wr_data = i_word_in;
                                    n_count = r_count + COUNT_BITS'(1);
                                end else begin
                                    rd_en   = 1'b1;
                                    rd_addr = ADDR_BITS'(r_count - COUNT_BITS'(1));
                                    n_dst   = ADDR_BITS'(r_count);
                                end
                            end
                            default: n_res_word = '0;
                        endcase
                    end
                end
            end
            S_FIRST: begin
                n_res_word = rd_data;
                if (r_kind == K_REMOVE) begin
                    if (rm_first_more) begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_BITS'(r_pos_ext + CMP_BITS'(1));
                        n_dst   = ADDR_BITS'(r_pos);
                    end else begin
                        n_count = r_count - COUNT_BITS'(1);
                    end
                end
            end
            S_SHIFT: begin
                wr_en = 1'b1;
                if (r_kind == K_INSERT) begin
                    if (ins_more) begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_BITS'(dst_ext - CMP_BITS'(2));
                        n_dst   = ADDR_BITS'(dst_ext - CMP_BITS'(1));
                    end
                end else begin
                    if (rm_more) begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_BITS'(dst_ext + CMP_BITS'(2));
                        n_dst   = ADDR_BITS'(dst_ext + CMP_BITS'(1));
                    end else begin
                        n_count = r_count - COUNT_BITS'(1);
                    end
                end
            end
            S_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = ADDR_BITS'(r_pos);
                wr_data = r_word;
                n_count = r_count + COUNT_BITS'(1);
            end
            S_DONE: begin
                n_count = r_count;
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_kind;
            r_pos  <= i_position;
            r_word <= i_word_in;
        end
        r_dst        <= n_dst;
        r_res_word   <= n_res_word;
        r_res_status <= n_res_status;
        if (r_state == S_DONE && out_free) begin
            r_out_word   <= r_res_word;
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_out     = r_out_word;
    assign o_status       = r_out_status;
    assign o_entries_used = r_out_count;

    `include "indexed_list_insert_remove_top_macros.svh"

    `ILIR_ASSERT_SAME(a_count_in_range, 1'b1,
        r_count <= COUNT_BITS'(CAPACITY), "count over capacity")

    `ILIR_ASSERT_NEXT(a_count_step, 1'b1,
        (r_count == $past(r_count)) ||
        (r_count == $past(r_count) + COUNT_BITS'(1)) ||
        (r_count == $past(r_count) - COUNT_BITS'(1)),
        "count moved by more than one")

    `ILIR_ASSERT_SAME(a_shift_writes, r_state == S_SHIFT, wr_en, "shift cycle without ram write")

    `ILIR_ASSERT_NEXT(a_done_delivers, r_state == S_DONE && out_free,
        o_out_valid && r_state == S_IDLE, "finished transaction not presented")

    `ILIR_ASSERT_SAME(a_failed_word_zero, r_state == S_DONE && r_res_status != ST_OK,
        r_res_word == '0, "failed transaction returns a word")

endmodule

`default_nettype wire

FILE: sv/ilir_ram.sv
// ----------------------------------------------------------------------------
// ilir_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_indexed_list_insert_remove_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove_top
// self-checking bench for the indexed word list: directed corner cases on an
// empty and a full list, then long random runs of every request kind that fill
// and drain the list under several sender and receiver idle patterns;
// every response is compared field by field against a local list model
// ----------------------------------------------------------------------------

module tb_indexed_list_insert_remove_top;
    import ilir_pkg::*;

    localparam logic [KIND_BITS-1:0] K_UNUSED_A = 3'd6;
    localparam logic [KIND_BITS-1:0] K_UNUSED_B = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 20;
    localparam int PHASE_ITEMS    = 410;
    localparam int MAX_PRINTS     = 60;

    typedef struct packed {
        logic [WORD_BITS-1:0]   word;
        logic [STATUS_BITS-1:0] status;
        logic [COUNT_BITS-1:0]  used;
    } t_list_resp;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [KIND_BITS-1:0]   i_kind         = '0;
    logic [POS_BITS-1:0]    i_position     = '0;
    logic [WORD_BITS-1:0]   i_word_in      = '0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [WORD_BITS-1:0]   o_word_out;
    logic [STATUS_BITS-1:0] o_status;
    logic [COUNT_BITS-1:0]  o_entries_used;

    // list model
    logic [WORD_BITS-1:0] list_words [0:CAPACITY-1];
    int                   list_len = 0;
    t_list_resp           pending_responses [$];

    int         mismatch_count = 0;
    int         idle_pct       = 0;
    int         stall_pct      = 0;
    int         quiet_cycles   = 0;
    bit         growing        = 1'b1;
    t_list_resp want;

    indexed_list_insert_remove_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .i_word_in      (i_word_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word_out     (o_word_out),
        .o_status       (o_status),
        .o_entries_used (o_entries_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // applies one request to the list model and returns its response
    function automatic t_list_resp apply_list_op(input logic [KIND_BITS-1:0] kind,
                                                 input int pos,
                                                 input logic [WORD_BITS-1:0] word);
        t_list_resp r;
        int         i;
        r.word   = '0;
        r.status = ST_OK;
        case (kind)
            K_PUSH: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            K_INSERT: begin
                // range is checked ahead of fullness
                if (pos > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = word;
                    list_len++;
                end
            end
            K_SET: begin
                if (pos >= list_len)
                    r.status = ST_RANGE;
                else
                    list_words[pos] = word;
            end
            K_POP: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_len--;
                    r.word = list_words[list_len];
                end
            end
            K_REMOVE: begin
                // emptiness is checked ahead of range
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.word = list_words[pos];
                    for (i = pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            K_GET: begin
                if (pos >= list_len)
                    r.status = ST_RANGE;
                else
                    r.word = list_words[pos];
            end
            default: begin
            end
        endcase
        r.used = COUNT_BITS'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // sends one transaction with a random lead-in gap
    task automatic send_request(input logic [KIND_BITS-1:0] kind,
                                input int pos,
                                input logic [WORD_BITS-1:0] word);
        int                  gap;
        logic [POS_BITS-1:0] pos_bits;
        gap      = 0;
        pos_bits = POS_BITS'(pos);
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_position <= pos_bits;
        i_word_in  <= word;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_responses.push_back(apply_list_op(kind, int'(pos_bits), word));
    endtask

    // holds the request side until every response is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_responses.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        send_request(K_POP, 0, 32'h1234_5678);
        send_request(K_REMOVE, 0, 0);
        send_request(K_REMOVE, CAPACITY, 0);
        send_request(K_GET, 0, 0);
        send_request(K_SET, 0, 32'hDEAD_BEEF);
        send_request(K_INSERT, 1, 32'hDEAD_BEEF);
        send_request(K_UNUSED_A, 0, 32'hFFFF_FFFF);
        send_request(K_UNUSED_B, 127, 32'hFFFF_FFFF);
    endtask

    task automatic test_basic_ops();
        send_request(K_INSERT, 0, 32'hA5A5_5A5A);
        send_request(K_PUSH, 0, 32'hFFFF_FFFF);
        send_request(K_PUSH, 127, 32'h0000_0000);
        send_request(K_INSERT, 3, 32'h1111_1111);   // append at the end
        send_request(K_INSERT, 1, 32'h2222_2222);
        send_request(K_SET, 2, 32'h8000_0001);
        send_request(K_GET, 0, 0);
        send_request(K_GET, 4, 0);
        send_request(K_GET, 5, 0);
        send_request(K_SET, 5, 32'h3333_3333);
        send_request(K_REMOVE, 5, 0);
        send_request(K_REMOVE, 1, 0);
        send_request(K_REMOVE, 0, 0);
        send_request(K_GET, CAPACITY, 0);
        send_request(K_POP, 0, 0);
        send_request(K_POP, 0, 0);
        send_request(K_POP, 0, 0);
    endtask

    task automatic test_full_list();
        int i;
        for (i = 0; i < CAPACITY; i++)
            send_request(K_PUSH, 0, $urandom());
        send_request(K_PUSH, 0, 32'hFFFF_FFFF);
        send_request(K_INSERT, CAPACITY, 32'hFFFF_FFFF);
        send_request(K_INSERT, 0, 32'hFFFF_FFFF);
        send_request(K_GET, CAPACITY - 1, 0);
        send_request(K_GET, CAPACITY, 0);
        send_request(K_SET, CAPACITY - 1, 32'hFFFF_FFFF);
        send_request(K_REMOVE, 0, 0);               // longest shift down
        send_request(K_INSERT, 0, 32'h0F0F_F0F0);   // longest shift up
        send_request(K_REMOVE, CAPACITY - 1, 0);
        send_request(K_INSERT, CAPACITY - 1, 32'h7FFF_FFFF);
        send_request(K_GET, 0, 0);
        for (i = 0; i <= CAPACITY; i++)
            send_request(K_POP, 0, 0);
    endtask

    // random traffic that swings the list between empty and full
    task automatic test_random_traffic(input int idle, input int stall, input int items);
        int                   sent;
        int                   roll;
        logic [KIND_BITS-1:0] kind;
        int                   pos;
        logic [WORD_BITS-1:0] word;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < items) begin
            if (list_len == CAPACITY)
                growing = 1'b0;
            else if (list_len == 0)
                growing = 1'b1;
            else if ($urandom_range(99) < 3)
                growing = !growing;

            roll = $urandom_range(99);
            if (roll < 3)
                kind = $urandom_range(1) ? K_UNUSED_A : K_UNUSED_B;
            else if (roll < 63)
                kind = growing ? ($urandom_range(1) ? K_PUSH : K_INSERT)
                               : ($urandom_range(1) ? K_POP : K_REMOVE);
            else if (roll < 75)
                kind = growing ? ($urandom_range(1) ? K_POP : K_REMOVE)
                               : ($urandom_range(1) ? K_PUSH : K_INSERT);
            else
                kind = $urandom_range(1) ? K_SET : K_GET;

            roll = $urandom_range(99);
            if (roll < 10)
                pos = $urandom_range(CAPACITY);
            else if (kind == K_INSERT)
                pos = (roll < 20) ? list_len : $urandom_range(list_len);
            else if (list_len == 0)
                pos = 0;
            else
                pos = (roll < 20) ? list_len - 1 : $urandom_range(list_len - 1);

            roll = $urandom_range(99);
            if (roll < 5)
                word = '0;
            else if (roll < 10)
                word = '1;
            else
                word = $urandom();

            send_request(kind, pos, word);
            if (kind != K_UNUSED_A && kind != K_UNUSED_B)
                sent++;
        end
        wait_drained();
    endtask

    // receiver stall pattern
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                want = pending_responses.pop_front();
                if (o_word_out !== want.word)
                    report_mismatch($sformatf("word_out got %h want %h",
                                              o_word_out, want.word));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                if (o_entries_used !== want.used)
                    report_mismatch($sformatf("entries_used got %0d want %0d",
                                              o_entries_used, want.used));
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_ops();
        test_full_list();
        wait_drained();

        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(67, 0, PHASE_ITEMS);
        test_random_traffic(0, 67, PHASE_ITEMS);
        test_random_traffic(32, 32, PHASE_ITEMS);

        i_in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
